// ===== hw/rtl/usbaps_pkg.sv =====
// shared types and constants for the usb audio packet sizer
// no dependencies, imported by every module of the block
package usbaps_pkg;

  localparam int unsigned PACKETS_PER_TRANSFER = 8;
  localparam int unsigned PKT_CNT_W = 7;
  localparam int unsigned ASM_FRM_W = 23;

  localparam logic [5:0]  FRAME_SIZE_RST   = 6'd4;
  localparam logic [31:0] NOMINAL_RATE_RST = 32'd393216;

  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 112;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_PACKET   = 2'd0,
    OP_FEEDBACK = 2'd1,
    OP_RESTART  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_SIZE   = 2'd0,
    REG_NOMINAL_RATE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [19:0] available_frames;
    logic [31:0] feedback_word;
    logic [2:0]  feedback_length;
    logic        feedback_ok;
  } item_t;

  typedef struct packed {
    logic [16:0] packet_frames;
    logic [21:0] packet_bytes;
    logic [5:0]  packet_index;
    logic        transfer_done;
    logic [27:0] transfer_bytes;
    logic        short_abort;
    logic        rate_updated;
    logic [31:0] current_rate;
  } result_t;

  typedef struct packed {
    logic [5:0]  frame_size;
    logic [31:0] nominal_rate;
  } cfg_t;

endpackage

// ===== hw/rtl/usbaps_cfg.sv =====
// configuration registers: frame size and nominal rate
// depends on usbaps_pkg
module usbaps_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [usbaps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data,
  output usbaps_pkg::cfg_t                cfg
);
  import usbaps_pkg::*;

  logic [5:0]  frame_size_r;
  logic [5:0]  frame_size_nxt;
  logic [31:0] nominal_rate_r;
  logic [31:0] nominal_rate_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    frame_size_nxt   = frame_size_r;
    nominal_rate_nxt = nominal_rate_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_SIZE:   frame_size_nxt   = cfg_data[5:0];
        REG_NOMINAL_RATE: nominal_rate_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r   <= FRAME_SIZE_RST;
      nominal_rate_r <= NOMINAL_RATE_RST;
    end else begin
      frame_size_r   <= frame_size_nxt;
      nominal_rate_r <= nominal_rate_nxt;
    end
  end

  assign cfg.frame_size   = frame_size_r;
  assign cfg.nominal_rate = nominal_rate_r;

endmodule

// ===== hw/rtl/usbaps_core.sv =====
// sizing datapath and stream state: rate, fraction accumulator, assembly counts
// depends on usbaps_pkg
module usbaps_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  usbaps_pkg::item_t    item,
  input  usbaps_pkg::cfg_t     cfg,
  output usbaps_pkg::result_t  res
);
  import usbaps_pkg::*;

  logic [31:0]          rate_r, rate_nxt;
  logic [15:0]          accum_r, accum_nxt;
  logic [PKT_CNT_W-1:0] pkts_r, pkts_nxt;
  logic [ASM_FRM_W-1:0] frms_r, frms_nxt;

  logic [31:0]          eff_rate;
  logic [32:0]          sum;
  logic [16:0]          frames;
  logic [19:0]          remaining;
  logic [ASM_FRM_W-1:0] new_frms;
  logic [PKT_CNT_W-1:0] new_pkts;
  logic [21:0]          pkt_bytes;
  logic [27:0]          xfer_bytes;
  logic [31:0]          fb_raw;

  assign eff_rate   = (rate_r != 32'd0) ? rate_r : cfg.nominal_rate;
  assign sum        = {17'd0, accum_r} + {1'b0, eff_rate};
  assign frames     = sum[32:16];
  assign remaining  = item.available_frames - frms_r[19:0];
  assign new_frms   = frms_r + {6'd0, frames};
  assign new_pkts   = pkts_r + 7'd1;
  assign pkt_bytes  = {5'd0, frames} * {16'd0, cfg.frame_size};
  assign xfer_bytes = {5'd0, new_frms} * {22'd0, cfg.frame_size};
  assign fb_raw     = (item.feedback_length >= 3'd4) ? item.feedback_word
                                                     : {8'd0, item.feedback_word[23:0]};

  always_comb begin
    rate_nxt  = rate_r;
    accum_nxt = accum_r;
    pkts_nxt  = pkts_r;
    frms_nxt  = frms_r;
    res       = '0;
    case (op_t'(item.operation))
      OP_PACKET: begin
        if (cfg.frame_size != 6'd0) begin
          res.packet_index = pkts_r[5:0];
          if (frms_r >= {3'd0, item.available_frames}) begin
            res.short_abort = 1'b1;
            pkts_nxt        = '0;
            frms_nxt        = '0;
          end else begin
            accum_nxt = sum[15:0];
            if ({3'd0, frames} > remaining) begin
              res.short_abort = 1'b1;
              pkts_nxt        = '0;
              frms_nxt        = '0;
            end else if (new_pkts >= PKT_CNT_W'(PACKETS_PER_TRANSFER)) begin
              pkts_nxt = '0;
              frms_nxt = '0;
              if (new_frms == '0) begin
                res.short_abort = 1'b1;
              end else begin
                res.packet_frames  = frames;
                res.packet_bytes   = pkt_bytes;
                res.transfer_done  = 1'b1;
                res.transfer_bytes = xfer_bytes;
              end
            end else begin
              pkts_nxt           = new_pkts;
              frms_nxt           = new_frms;
              res.packet_frames  = frames;
              res.packet_bytes   = pkt_bytes;
            end
          end
        end
      end
      OP_FEEDBACK: begin
        if (item.feedback_ok && item.feedback_length >= 3'd3) begin
          rate_nxt         = fb_raw;
          res.rate_updated = 1'b1;
        end
      end
      OP_RESTART: begin
        rate_nxt  = '0;
        accum_nxt = '0;
        pkts_nxt  = '0;
        frms_nxt  = '0;
      end
      default: ;
    endcase
    res.current_rate = (rate_nxt != 32'd0) ? rate_nxt : cfg.nominal_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      accum_r <= '0;
      pkts_r  <= '0;
      frms_r  <= '0;
    end else if (step) begin
      rate_r  <= rate_nxt;
      accum_r <= accum_nxt;
      pkts_r  <= pkts_nxt;
      frms_r  <= frms_nxt;
    end
  end

endmodule

// ===== hw/rtl/usb_audio_packet_sizer_top.sv =====
// pipeline: each input beat passes through the input register and then the result register
// throughput: one beat per cycle while out_tready is not held low, set by the input register feeding the
// sizing logic and the result register, with the stream state updated as
// each item leaves the input register
// reset: synchronous active-low rst_n clears pipeline valids and state,
// frame size returns to 4 and nominal rate to 393216
// depends on usbaps_pkg, usbaps_cfg, usbaps_core
module usb_audio_packet_sizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // operation
  input  logic [1:0]                          in_tuser,
  // available_frames, feedback_word, feedback_length, feedback_ok
  input  logic [usbaps_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // transfer_done
  output logic                                out_tlast,
  // short_abort, rate_updated
  output logic [1:0]                          out_tuser,
  // packet_frames, packet_bytes, packet_index, transfer_bytes, current_rate
  output logic [usbaps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [usbaps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);
  import usbaps_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    out_adv;
  logic    in_adv;

  usbaps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_adv   = !res_vld_r || out_tready;
  assign in_adv    = !item_vld_r || out_adv;
  assign in_tready = in_adv;

  usbaps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (item_vld_r && out_adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_adv) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_tvalid) begin
      item_r.operation        <= in_tuser;
      item_r.available_frames <= in_tdata[19:0];
      item_r.feedback_word    <= in_tdata[51:20];
      item_r.feedback_length  <= in_tdata[54:52];
      item_r.feedback_ok      <= in_tdata[55];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (out_adv) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && item_vld_r) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tlast  = res_r.transfer_done;
  assign out_tuser  = {res_r.rate_updated, res_r.short_abort};
  assign out_tdata  = {7'd0, res_r.current_rate, res_r.transfer_bytes,
                       res_r.packet_index, res_r.packet_bytes, res_r.packet_frames};

endmodule
